// ----- design/adp_pkg.sv -----
`default_nettype none

package adp_pkg;

	// Data-processing opcodes, instruction bits 24..21.
	typedef enum logic [3:0] {
		OP_AND = 4'd0,
		OP_EOR = 4'd1,
		OP_SUB = 4'd2,
		OP_RSB = 4'd3,
		OP_ADD = 4'd4,
		OP_ADC = 4'd5,
		OP_SBC = 4'd6,
		OP_RSC = 4'd7,
		OP_TST = 4'd8,
		OP_TEQ = 4'd9,
		OP_CMP = 4'd10,
		OP_CMN = 4'd11,
		OP_ORR = 4'd12,
		OP_MOV = 4'd13,
		OP_BIC = 4'd14,
		OP_MVN = 4'd15
	} opcode_t;

	// Shift types, instruction bits 6..5.
	typedef enum logic [1:0] {
		SHIFT_LSL = 2'd0,
		SHIFT_LSR = 2'd1,
		SHIFT_ASR = 2'd2,
		SHIFT_ROR = 2'd3
	} shift_kind_t;

	localparam int unsigned WORD_W = 32;

	// Shifter operand and shifter carry out.
	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic              carry;
	} shift_res_t;

endpackage

`default_nettype wire

// ----- design/adp_shifter.sv -----
`default_nettype none

module adp_shifter
	import adp_pkg::*;
(
	input  wire logic [31:0] instr,
	input  wire logic        operand_is_immediate,
	input  wire logic [31:0] rm_value,
	input  wire logic [7:0]  rs_value,
	input  wire logic        carry_in,
	output shift_res_t       shift
);

	// Shift of Rm by a decoded amount, where zero means no shift at all.
	function automatic shift_res_t shift_reg(input logic [31:0] rm, input logic [1:0] kind,
			input logic [7:0] amt, input logic cin);
		logic [32:0] wide;
		logic [63:0] dbl;
		logic        big;
		logic        exact;
		shift_res_t  r;
		wide  = '0;
		dbl   = '0;
		big   = (amt[7:5] != 3'b000);
		exact = (amt == 8'd32);
		r     = '{value: rm, carry: cin};
		if (amt != 8'd0) begin
			case (kind)
				SHIFT_LSL: begin
					wide = {1'b0, rm} << amt[4:0];
					r.value = big ? '0 : wide[31:0];
					r.carry = big ? (exact & rm[0]) : wide[32];
				end
				SHIFT_LSR: begin
					wide = {rm, 1'b0} >> amt[4:0];
					r.value = big ? '0 : wide[32:1];
					r.carry = big ? (exact & rm[31]) : wide[0];
				end
				SHIFT_ASR: begin
					wide = $signed({rm, 1'b0}) >>> amt[4:0];
					r.value = big ? {32{rm[31]}} : wide[32:1];
					r.carry = big ? rm[31] : wide[0];
				end
				SHIFT_ROR: begin
					// A multiple of 32 leaves Rm in place; the carry is still bit 31.
					dbl = {rm, rm} >> amt[4:0];
					r.value = dbl[31:0];
					r.carry = dbl[31];
				end
				default: begin
					r = '{value: rm, carry: cin};
				end
			endcase
		end
		return r;
	endfunction

	logic [4:0]  rot_amt;
	logic [63:0] imm_dbl;
	logic [4:0]  imm_amt;
	logic [1:0]  kind;

	assign rot_amt = {instr[11:8], 1'b0};
	assign imm_dbl = {24'd0, instr[7:0], 24'd0, instr[7:0]} >> rot_amt;
	assign imm_amt = instr[11:7];
	assign kind    = instr[6:5];

	// Operand selection: rotated immediate, register-amount or immediate-amount shift.
	always_comb begin
		if (operand_is_immediate) begin
			shift.value = imm_dbl[31:0];
			shift.carry = (rot_amt == 5'd0) ? carry_in : imm_dbl[31];
		end else if (instr[4]) begin
			shift = shift_reg(rm_value, kind, rs_value, carry_in);
		end else if (imm_amt == 5'd0 && kind == SHIFT_LSL) begin
			shift = '{value: rm_value, carry: carry_in};
		end else if (imm_amt == 5'd0 && kind == SHIFT_ROR) begin
			// Rotate right extended through the carry.
			shift = '{value: {carry_in, rm_value[31:1]}, carry: rm_value[0]};
		end else if (imm_amt == 5'd0) begin
			// LSR and ASR by zero encode a shift by 32.
			shift = shift_reg(rm_value, kind, 8'd32, carry_in);
		end else begin
			shift = shift_reg(rm_value, kind, {3'b000, imm_amt}, carry_in);
		end
	end

endmodule

`default_nettype wire

// ----- design/arm_data_processing_alu.sv -----
// Channel  Handshake               Fields
// in       in_valid / in_stall     instr, operand_is_immediate, rn_value, rm_value,
//                                  rs_value, carry_in, overflow_in
// out      out_valid / out_stall   result, dest_reg, write_reg, flags_write,
//                                  flag_n, flag_z, flag_c, flag_v, restore_cpsr
//
// One beat in and one beat out per clock while out_stall is low; each accepted beat
// passes the input register, then the result register, on its way to the outputs.
// The barrel shifter and the 32-bit adder sit between the two registers.
// arst_n clears both stage valids; payload registers are not reset.
// in_stall rises only when the input register holds a beat and the result register
// is full and stalled.
`default_nettype none

module arm_data_processing_alu
	import adp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] instr,
	input  wire logic        operand_is_immediate,
	input  wire logic [31:0] rn_value,
	input  wire logic [31:0] rm_value,
	input  wire logic [7:0]  rs_value,
	input  wire logic        carry_in,
	input  wire logic        overflow_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      result,
	output logic [3:0]       dest_reg,
	output logic             write_reg,
	output logic             flags_write,
	output logic             flag_n,
	output logic             flag_z,
	output logic             flag_c,
	output logic             flag_v,
	output logic             restore_cpsr
);

	logic        valid_s1;
	logic [31:0] instr_s1;
	logic        imm_s1;
	logic [31:0] rn_s1;
	logic [31:0] rm_s1;
	logic [7:0]  rs_s1;
	logic        cin_s1;
	logic        vin_s1;

	logic        valid_s2;
	logic [31:0] result_s2;
	logic [3:0]  dest_s2;
	logic        write_s2;
	logic        fwrite_s2;
	logic        n_s2;
	logic        z_s2;
	logic        c_s2;
	logic        v_s2;
	logic        restore_s2;

	logic        adv_s2;
	logic        adv_s1;

	// Handshake: the result register frees up when empty or taken.
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			instr_s1 <= instr;
			imm_s1   <= operand_is_immediate;
			rn_s1    <= rn_value;
			rm_s1    <= rm_value;
			rs_s1    <= rs_value;
			cin_s1   <= carry_in;
			vin_s1   <= overflow_in;
		end
	end

	// Shifter operand.
	shift_res_t shift;

	adp_shifter u_shifter (
		.instr                (instr_s1),
		.operand_is_immediate (imm_s1),
		.rm_value             (rm_s1),
		.rs_value             (rs_s1),
		.carry_in             (cin_s1),
		.shift                (shift)
	);

	opcode_t     opcode;
	logic        s_bit;
	logic        rd_pc;
	logic        is_cmp;
	logic        arith;
	logic [31:0] add_a;
	logic [31:0] add_b;
	logic        add_cin;
	logic [32:0] sum;
	logic [31:0] logic_res;
	logic [31:0] alu_res;
	logic        alu_c;
	logic        alu_v;

	assign opcode = opcode_t'(instr_s1[24:21]);
	assign s_bit  = instr_s1[20];
	assign rd_pc  = (instr_s1[15:12] == 4'd15);
	assign is_cmp = (opcode inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN});

	// Adder operands and the logical result for each opcode.
	always_comb begin
		arith     = 1'b0;
		add_a     = rn_s1;
		add_b     = shift.value;
		add_cin   = 1'b0;
		logic_res = '0;
		case (opcode)
			OP_AND, OP_TST: logic_res = rn_s1 & shift.value;
			OP_EOR, OP_TEQ: logic_res = rn_s1 ^ shift.value;
			OP_SUB, OP_CMP: begin
				arith = 1'b1; add_b = ~shift.value; add_cin = 1'b1;
			end
			OP_RSB: begin
				arith = 1'b1; add_a = shift.value; add_b = ~rn_s1; add_cin = 1'b1;
			end
			OP_ADD, OP_CMN: arith = 1'b1;
			OP_ADC: begin
				arith = 1'b1; add_cin = cin_s1;
			end
			OP_SBC: begin
				arith = 1'b1; add_b = ~shift.value; add_cin = cin_s1;
			end
			OP_RSC: begin
				arith = 1'b1; add_a = shift.value; add_b = ~rn_s1; add_cin = cin_s1;
			end
			OP_ORR: logic_res = rn_s1 | shift.value;
			OP_MOV: logic_res = shift.value;
			OP_BIC: logic_res = rn_s1 & ~shift.value;
			OP_MVN: logic_res = ~shift.value;
			default: logic_res = ~shift.value;
		endcase
	end

	// Adder and flag sources: the adder for arithmetic; otherwise the shifter carry and overflow_in.
	assign sum     = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
	assign alu_res = arith ? sum[31:0] : logic_res;
	assign alu_c   = arith ? sum[32] : shift.carry;
	assign alu_v   = arith ? (((add_a ^ sum[31:0]) & (add_b ^ sum[31:0])) >> 31) != 32'd0
			: vin_s1;

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2  <= alu_res;
			dest_s2    <= instr_s1[15:12];
			write_s2   <= !is_cmp;
			fwrite_s2  <= is_cmp || (s_bit && !rd_pc);
			n_s2       <= alu_res[31];
			z_s2       <= (alu_res == 32'd0);
			c_s2       <= alu_c;
			v_s2       <= alu_v;
			restore_s2 <= !is_cmp && s_bit && rd_pc;
		end
	end

	assign out_valid    = valid_s2;
	assign result       = result_s2;
	assign dest_reg     = dest_s2;
	assign write_reg    = write_s2;
	assign flags_write  = fwrite_s2;
	assign flag_n       = n_s2;
	assign flag_z       = z_s2;
	assign flag_c       = c_s2;
	assign flag_v       = v_s2;
	assign restore_cpsr = restore_s2;

`ifndef SYNTHESIS
	// Back pressure reaches the input only with a beat parked in the input register.
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("in_stall raised with an empty input register");

	// A held beat moves to the output when the output is free.
	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_stall) |=> out_valid)
		else $error("input register beat did not reach the output");

	// A CPSR restore never coincides with a flag update.
	a_restore_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(restore_cpsr && flags_write))
		else $error("restore_cpsr and flags_write both set");

	// Compares always update flags.
	a_cmp_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !write_reg) |-> flags_write)
		else $error("compare opcode without flag update");
`endif

endmodule

`default_nettype wire

// ----- test/tb_arm_data_processing_alu.sv -----
`default_nettype none

module tb_arm_data_processing_alu;

	timeunit 1ns;
	timeprecision 1ps;

	import adp_pkg::*;

	localparam int RANDOM_BEATS = 1200;
	localparam int CALM_BEATS = 200;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 400000;

	// One instruction beat as it enters the block.
	typedef struct packed {
		logic [31:0] instr;
		logic        operand_is_immediate;
		logic [31:0] rn_value;
		logic [31:0] rm_value;
		logic [7:0]  rs_value;
		logic        carry_in;
		logic        overflow_in;
	} alu_in_t;

	// One result beat as it leaves the block.
	typedef struct packed {
		logic [31:0] result;
		logic [3:0]  dest_reg;
		logic        write_reg;
		logic        flags_write;
		logic        flag_n;
		logic        flag_z;
		logic        flag_c;
		logic        flag_v;
		logic        restore_cpsr;
	} alu_out_t;

	// Predicts each executed instruction and matches the results in order.
	class alu_scoreboard;
		alu_out_t    expected_q[$];
		int unsigned mismatches;
		int unsigned beats_noted;
		int unsigned results_checked;

		function logic [31:0] rotate_right(logic [31:0] v, int unsigned amt);
			logic [63:0] both;
			both = {v, v} >> (amt % 32);
			return both[31:0];
		endfunction

		// Register-form barrel shifter; an amount of zero passes Rm and the carry.
		function shift_res_t barrel_shift(logic [31:0] rm, shift_kind_t kind,
				int unsigned amt, logic cin);
			shift_res_t r;
			r.value = rm;
			r.carry = cin;
			if (amt == 0)
				return r;
			case (kind)
				SHIFT_LSL: begin
					if (amt < 32) begin
						r.value = rm << amt;
						r.carry = rm[32 - amt];
					end else begin
						r.value = '0;
						r.carry = (amt == 32) ? rm[0] : 1'b0;
					end
				end
				SHIFT_LSR: begin
					if (amt < 32) begin
						r.value = rm >> amt;
						r.carry = rm[amt - 1];
					end else begin
						r.value = '0;
						r.carry = (amt == 32) ? rm[31] : 1'b0;
					end
				end
				SHIFT_ASR: begin
					if (amt < 32) begin
						r.value = $signed(rm) >>> amt;
						r.carry = rm[amt - 1];
					end else begin
						r.value = {32{rm[31]}};
						r.carry = rm[31];
					end
				end
				default: begin
					if (amt % 32 == 0) begin
						r.value = rm;
						r.carry = rm[31];
					end else begin
						r.value = rotate_right(rm, amt);
						r.carry = rm[(amt % 32) - 1];
					end
				end
			endcase
			return r;
		endfunction

		function alu_out_t predict_execute(alu_in_t b);
			opcode_t     op;
			shift_kind_t kind;
			shift_res_t  opnd;
			int unsigned rot;
			int unsigned amt;
			logic [31:0] a;
			logic [31:0] addend;
			logic [31:0] res;
			logic [32:0] sum;
			logic        carry_add;
			logic        arith;
			logic        compare_op;
			logic        s_bit;
			logic        c;
			logic        v;
			alu_out_t    o;

			op = opcode_t'(b.instr[24:21]);
			s_bit = b.instr[20];

			// Shifter operand and shifter carry.
			if (b.operand_is_immediate) begin
				rot = b.instr[11:8] * 2;
				opnd.value = rotate_right({24'd0, b.instr[7:0]}, rot);
				opnd.carry = (rot == 0) ? b.carry_in : opnd.value[31];
			end else begin
				kind = shift_kind_t'(b.instr[6:5]);
				amt = b.instr[11:7];
				if (b.instr[4]) begin
					opnd = barrel_shift(b.rm_value, kind, b.rs_value, b.carry_in);
				end else if (amt == 0 && kind == SHIFT_ROR) begin
					opnd.value = {b.carry_in, b.rm_value[31:1]};
					opnd.carry = b.rm_value[0];
				end else begin
					// An immediate amount of zero means 32 for LSR and ASR.
					if (amt == 0 && kind != SHIFT_LSL)
						amt = 32;
					opnd = barrel_shift(b.rm_value, kind, amt, b.carry_in);
				end
			end

			// ALU operation.
			arith = 1'b0;
			a = '0;
			addend = '0;
			carry_add = 1'b0;
			res = '0;
			case (op)
				OP_AND, OP_TST: res = b.rn_value & opnd.value;
				OP_EOR, OP_TEQ: res = b.rn_value ^ opnd.value;
				OP_SUB, OP_CMP: begin
					a = b.rn_value; addend = ~opnd.value; carry_add = 1'b1; arith = 1'b1;
				end
				OP_RSB: begin
					a = opnd.value; addend = ~b.rn_value; carry_add = 1'b1; arith = 1'b1;
				end
				OP_ADD, OP_CMN: begin
					a = b.rn_value; addend = opnd.value; carry_add = 1'b0; arith = 1'b1;
				end
				OP_ADC: begin
					a = b.rn_value; addend = opnd.value; carry_add = b.carry_in; arith = 1'b1;
				end
				OP_SBC: begin
					a = b.rn_value; addend = ~opnd.value; carry_add = b.carry_in; arith = 1'b1;
				end
				OP_RSC: begin
					a = opnd.value; addend = ~b.rn_value; carry_add = b.carry_in; arith = 1'b1;
				end
				OP_ORR: res = b.rn_value | opnd.value;
				OP_MOV: res = opnd.value;
				OP_BIC: res = b.rn_value & ~opnd.value;
				default: res = ~opnd.value;
			endcase

			if (arith) begin
				sum = {1'b0, a} + {1'b0, addend} + carry_add;
				res = sum[31:0];
				c = sum[32];
				v = (a[31] ^ res[31]) & (addend[31] ^ res[31]);
			end else begin
				c = opnd.carry;
				v = b.overflow_in;
			end

			// Write enables and the SPSR restore case.
			compare_op = op inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN};
			o.result = res;
			o.dest_reg = b.instr[15:12];
			o.write_reg = !compare_op;
			o.flags_write = compare_op || (s_bit && b.instr[15:12] != 4'hF);
			o.flag_n = res[31];
			o.flag_z = (res == 32'd0);
			o.flag_c = c;
			o.flag_v = v;
			o.restore_cpsr = !compare_op && s_bit && b.instr[15:12] == 4'hF;
			return o;
		endfunction

		function string describe(alu_out_t r);
			return $sformatf("res=%h rd=%0d wr=%b fw=%b nzcv=%b%b%b%b rst=%b", r.result,
				r.dest_reg, r.write_reg, r.flags_write, r.flag_n, r.flag_z, r.flag_c,
				r.flag_v, r.restore_cpsr);
		endfunction

		function void note_input(alu_in_t b);
			expected_q.push_back(predict_execute(b));
			beats_noted++;
		endfunction

		function void check_result(alu_out_t got);
			alu_out_t want;
			logic     bad;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: %s", describe(got));
				return;
			end
			want = expected_q.pop_front();
			results_checked++;
			bad = (got.result !== want.result) || (got.dest_reg !== want.dest_reg) ||
				(got.write_reg !== want.write_reg) || (got.flags_write !== want.flags_write) ||
				(got.flag_n !== want.flag_n) || (got.flag_z !== want.flag_z) ||
				(got.flag_c !== want.flag_c) || (got.flag_v !== want.flag_v) ||
				(got.restore_cpsr !== want.restore_cpsr);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch on result %0d", results_checked);
					$display("  expected %s", describe(want));
					$display("  actual   %s", describe(got));
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] instr;
	logic        operand_is_immediate;
	logic [31:0] rn_value;
	logic [31:0] rm_value;
	logic [7:0]  rs_value;
	logic        carry_in;
	logic        overflow_in;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] result;
	logic [3:0]  dest_reg;
	logic        write_reg;
	logic        flags_write;
	logic        flag_n;
	logic        flag_z;
	logic        flag_c;
	logic        flag_v;
	logic        restore_cpsr;

	alu_scoreboard sb;
	bit            idle_on = 1'b1;
	int            cycle_count = 0;
	int            directed_beats = 0;

	arm_data_processing_alu DUT (.*);

	// Clock.
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Sample both handshakes at the rising edge.
	always @(posedge clk) begin : sample_beats
		alu_out_t got;
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_input({instr, operand_is_immediate, rn_value, rm_value, rs_value,
					carry_in, overflow_in});
			if (out_valid && !out_stall) begin
				got = {result, dest_reg, write_reg, flags_write, flag_n, flag_z, flag_c,
					flag_v, restore_cpsr};
				sb.check_result(got);
			end
		end
	end

	// Result side: random stall bursts between free-running stretches.
	initial begin
		out_stall = 1'b0;
		forever begin
			if (idle_on && arst_n && $urandom_range(0, 2) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			out_stall = 1'b0;
			repeat ($urandom_range(1, 30)) @(negedge clk);
		end
	end

	// Present one beat at a falling edge and hold it until accepted.
	task automatic send_beat(input alu_in_t b);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		instr = b.instr;
		operand_is_immediate = b.operand_is_immediate;
		rn_value = b.rn_value;
		rm_value = b.rm_value;
		rs_value = b.rs_value;
		carry_in = b.carry_in;
		overflow_in = b.overflow_in;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Hold off new beats until every outstanding result has come back.
	task automatic wait_for_drain();
		in_valid = 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
	endtask

	task automatic send_dp(input opcode_t op, input bit s, input bit [3:0] rd,
			input bit imm, input bit [11:0] shifter_bits, input logic [31:0] rn,
			input logic [31:0] rm, input logic [7:0] rs, input bit cin, input bit vin);
		alu_in_t b;
		b.instr = {4'hE, 2'b00, imm, op, s, 4'h0, rd, shifter_bits};
		b.instr[19:16] = 4'($urandom_range(0, 15));
		b.operand_is_immediate = imm;
		b.rn_value = rn;
		b.rm_value = rm;
		b.rs_value = rs;
		b.carry_in = cin;
		b.overflow_in = vin;
		send_beat(b);
		directed_beats++;
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return 32'h0000_0001;
			default: return $urandom;
		endcase
	endfunction

	// Random instruction with the shift amounts and operands pushed toward edges.
	function automatic alu_in_t random_beat();
		alu_in_t b;
		b.instr = $urandom;
		b.operand_is_immediate = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 3) == 0)
			b.instr[15:12] = 4'hF;
		if (!b.instr[4] && $urandom_range(0, 3) == 0)
			b.instr[11:7] = 5'd0;
		if (b.operand_is_immediate && $urandom_range(0, 3) == 0)
			b.instr[11:8] = 4'd0;
		b.rn_value = pick_word();
		b.rm_value = pick_word();
		case ($urandom_range(0, 5))
			0: b.rs_value = 8'd0;
			1: b.rs_value = 8'd32;
			2: b.rs_value = 8'($urandom_range(1, 31));
			3: b.rs_value = 8'($urandom_range(33, 255));
			4: b.rs_value = 8'($urandom_range(1, 7) * 32);
			default: b.rs_value = 8'($urandom_range(0, 255));
		endcase
		b.carry_in = 1'($urandom_range(0, 1));
		b.overflow_in = 1'($urandom_range(0, 1));
		return b;
	endfunction

	// Main sequence: reset, directed cases, random instructions, drain.
	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		instr = '0;
		operand_is_immediate = 1'b0;
		rn_value = '0;
		rm_value = '0;
		rs_value = '0;
		carry_in = 1'b0;
		overflow_in = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Every opcode, each paired with a shifter corner.
		send_dp(OP_AND, 1, 4'd1, 1, 12'h0FF, 32'hFFFF_FFFF, 0, 0, 1, 0);
		send_dp(OP_EOR, 1, 4'd2, 1, 12'h4F0, 32'hFFFF_FFFF, 0, 0, 0, 1);
		send_dp(OP_SUB, 1, 4'd3, 0, 12'h000, 32'h0, 32'h1, 0, 1, 0);
		send_dp(OP_RSB, 1, 4'd4, 0, 12'h020, 32'h1, 32'h8000_0000, 0, 0, 0);
		send_dp(OP_ADD, 1, 4'd5, 0, 12'h040, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
		send_dp(OP_ADC, 1, 4'd6, 0, 12'h060, 32'hFFFF_FFFF, 32'h1, 0, 1, 0);
		send_dp(OP_SBC, 1, 4'd7, 0, 12'h010, 32'h8000_0000, 32'h1, 8'd32, 0, 0);
		send_dp(OP_RSC, 1, 4'd8, 0, 12'h010, 32'h0, 32'hFFFF_FFFF, 8'd40, 1, 1);
		send_dp(OP_TST, 0, 4'hF, 0, 12'h030, 32'hFFFF_FFFF, 32'h8000_0000, 8'd32, 0, 1);
		send_dp(OP_TEQ, 0, 4'd9, 0, 12'h030, 32'h1234_5678, 32'hFFFF_FFFF, 8'd255, 1, 0);
		send_dp(OP_CMP, 1, 4'hF, 0, 12'h050, 32'h8000_0000, 32'h8000_0000, 8'd100, 0, 0);
		send_dp(OP_CMN, 0, 4'd10, 0, 12'h070, 32'hFFFF_FFFF, 32'h8000_0001, 8'd64, 0, 0);
		send_dp(OP_ORR, 1, 4'd11, 0, 12'h070, 32'h0, 32'h8000_0001, 8'd32, 0, 1);
		send_dp(OP_MOV, 1, 4'hF, 0, 12'h010, 32'h0, 32'hCAFE_F00D, 8'd0, 1, 0);
		send_dp(OP_BIC, 1, 4'd12, 0, 12'h090, 32'hFFFF_FFFF, 32'hF0F0_F0F0, 8'd5, 0, 0);
		send_dp(OP_MVN, 0, 4'hF, 1, 12'hFFF, 32'h0, 32'h0, 0, 0, 1);
		// Signed overflow, zero result and the remaining immediate shifts.
		send_dp(OP_ADD, 1, 4'd13, 1, 12'h001, 32'h7FFF_FFFF, 0, 0, 0, 0);
		send_dp(OP_SUB, 1, 4'd14, 0, 12'h000, 32'h1234_5678, 32'h1234_5678, 0, 0, 1);
		send_dp(OP_MOV, 1, 4'd0, 0, 12'h0E0, 32'h0, 32'h0000_0001, 0, 0, 0);
		send_dp(OP_MOV, 1, 4'd1, 0, 12'hF80, 32'h0, 32'h0000_0003, 0, 0, 0);
		send_dp(OP_MOV, 1, 4'd2, 0, 12'h0C0, 32'h0, 32'h8000_0001, 0, 0, 0);
		send_dp(OP_AND, 0, 4'd3, 0, 12'h000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, 1);
		wait_for_drain();

		// Random instructions; the closing stretch runs with no idling.
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if (i == RANDOM_BEATS / 2)
				wait_for_drain();
			if (i == RANDOM_BEATS - CALM_BEATS)
				idle_on = 1'b0;
			send_beat(random_beat());
		end
		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Executed %0d instruction beats (%0d directed), checked %0d results.",
			sb.beats_noted, directed_beats, sb.results_checked);
		$display("Covered all opcodes, both operand forms and every shift corner; %0d bad.",
			sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
